// ----- sv/swarq_pkg.sv -----
package swarq_pkg;

    localparam int WIN_DEPTH   = 16;
    localparam int MAX_PAYLOAD = 1464;

    localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int WRAP_W    = IDX_W + 1;
    localparam int TOTAL_W   = 40;
    localparam int TIMEOUT_W = 16;
    localparam int SEQ_W     = 32;
    localparam int BYTES_W   = 11;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 40;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(80);

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = CFG_IDX_W'(1);

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_ACK  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW    = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic fill_step;
        logic finish_step;
        logic ack_step;
        logic flush_step;
    } cmd_t;

    typedef struct packed {
        logic scan_more;
        logic fill_more;
        logic emit_ok;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

// ----- sv/swarq_ctrl.sv -----
module swarq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                mode,
    output logic                in_stall,
    input  swarq_pkg::status_t  st,
    output swarq_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_FILL   = 6'b000100,
        ST_FINISH = 6'b001000,
        ST_ACK    = 6'b010000,
        ST_FLUSH  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = (mode == swarq_pkg::MODE_ACK) ? ST_ACK : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!st.scan_more)
                begin
                    state_next = ST_FILL;
                end
                else if (st.emit_ok)
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FILL:
            begin
                if (!st.fill_more)
                begin
                    state_next = ST_FINISH;
                end
                else if (st.emit_ok)
                begin
                    cmd.fill_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (st.emit_ok)
                begin
                    cmd.finish_step = 1'b1;
                    state_next      = ST_FLUSH;
                end
            end
            ST_ACK:
            begin
                if (st.emit_ok)
                begin
                    cmd.ack_step = 1'b1;
                    state_next   = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!st.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush_step = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/swarq_dp.sv -----
module swarq_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  mode,
    input  logic [swarq_pkg::SEQ_W-1:0]           ack_seq,
    input  logic                                  cfg_we,
    input  logic [swarq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swarq_pkg::CFG_W-1:0]           cfg_data,
    input  swarq_pkg::cmd_t                       cmd,
    output swarq_pkg::status_t                    st,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [swarq_pkg::KIND_W-1:0]          kind,
    output logic [swarq_pkg::SEQ_W-1:0]           seq_num,
    output logic [swarq_pkg::BYTES_W-1:0]         payload_bytes,
    output logic                                  last
);

    localparam int W       = swarq_pkg::WIN_DEPTH;
    localparam int IDX_W   = swarq_pkg::IDX_W;
    localparam int CNT_W   = swarq_pkg::CNT_W;
    localparam int WRAP_W  = swarq_pkg::WRAP_W;
    localparam int SEQ_W   = swarq_pkg::SEQ_W;
    localparam int TOT_W   = swarq_pkg::TOTAL_W;
    localparam int TMO_W   = swarq_pkg::TIMEOUT_W;
    localparam int BYTES_W = swarq_pkg::BYTES_W;

    logic [TMO_W-1:0]   timeout_reg, timeout_next;
    logic [TOT_W-1:0]   remaining_reg, remaining_next;
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]   outstanding_reg, outstanding_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               all_loaded_reg, all_loaded_next;
    logic               done_reg, done_next;
    logic [SEQ_W-1:0]   now_reg, now_next;
    logic [SEQ_W-1:0]   ack_reg, ack_next;

    logic [SEQ_W-1:0]   stamp_reg [W];
    logic [BYTES_W-1:0] size_reg [W];

    logic                 pend_valid_reg, pend_valid_next;
    swarq_pkg::kind_t     pend_kind_reg, pend_kind_next;
    logic [SEQ_W-1:0]     pend_seq_reg, pend_seq_next;
    logic [BYTES_W-1:0]   pend_bytes_reg, pend_bytes_next;

    logic                 out_valid_reg, out_valid_next;
    swarq_pkg::kind_t     out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]     out_seq_reg, out_seq_next;
    logic [BYTES_W-1:0]   out_bytes_reg, out_bytes_next;
    logic                 out_last_reg, out_last_next;

    logic [CNT_W-1:0]     offset;
    logic [WRAP_W-1:0]    slot_sum;
    logic [WRAP_W-1:0]    slot_wrap;
    logic [IDX_W-1:0]     slot;
    logic [SEQ_W-1:0]     rd_stamp;
    logic [BYTES_W-1:0]   rd_size;
    logic [SEQ_W-1:0]     age;
    logic                 timed_out;
    logic                 rem_short;
    logic [BYTES_W-1:0]   chunk;
    logic [SEQ_W-1:0]     ack_dist;
    logic [CNT_W-1:0]     drop;
    logic [WRAP_W-1:0]    head_sum;
    logic [WRAP_W-1:0]    head_wrap;

    logic                 wr_en;
    logic [SEQ_W-1:0]     wr_stamp;
    logic [BYTES_W-1:0]   wr_size;
    logic                 wr_size_en;

    logic                 produce;
    swarq_pkg::kind_t     new_kind;
    logic [SEQ_W-1:0]     new_seq;
    logic [BYTES_W-1:0]   new_bytes;
    logic                 push;
    logic                 out_free;

    assign out_free = !out_valid_reg || !out_stall;

    assign st.scan_more  = (idx_reg < outstanding_reg);
    assign st.fill_more  = !all_loaded_reg && (outstanding_reg < CNT_W'(W));
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;
    assign st.emit_ok    = !pend_valid_reg || out_free;

    assign offset    = cmd.fill_step ? outstanding_reg : idx_reg;
    assign slot_sum  = WRAP_W'(head_reg) + WRAP_W'(offset);
    assign slot_wrap = (slot_sum >= WRAP_W'(W)) ? (slot_sum - WRAP_W'(W)) : slot_sum;
    assign slot      = slot_wrap[IDX_W-1:0];
    assign rd_stamp  = stamp_reg[slot];
    assign rd_size   = size_reg[slot];
    assign age       = now_reg - rd_stamp;
    assign timed_out = (age > SEQ_W'(timeout_reg));

    assign rem_short = (remaining_reg < TOT_W'(swarq_pkg::MAX_PAYLOAD));
    assign chunk     = rem_short ? remaining_reg[BYTES_W-1:0]
                                 : BYTES_W'(swarq_pkg::MAX_PAYLOAD);

    assign ack_dist  = ack_reg - base_reg;
    assign drop      = CNT_W'(ack_dist) + CNT_W'(1);
    assign head_sum  = WRAP_W'(head_reg) + WRAP_W'(drop);
    assign head_wrap = (head_sum >= WRAP_W'(W)) ? (head_sum - WRAP_W'(W)) : head_sum;

    always_comb
    begin
        timeout_next     = timeout_reg;
        remaining_next   = remaining_reg;
        next_seq_next    = next_seq_reg;
        base_next        = base_reg;
        outstanding_next = outstanding_reg;
        head_next        = head_reg;
        idx_next         = idx_reg;
        all_loaded_next  = all_loaded_reg;
        done_next        = done_reg;
        now_next         = now_reg;
        ack_next         = ack_reg;
        wr_en            = 1'b0;
        wr_size_en       = 1'b0;
        wr_stamp         = now_reg;
        wr_size          = chunk;
        produce          = 1'b0;
        new_kind         = swarq_pkg::KIND_NEW;
        new_seq          = next_seq_reg;
        new_bytes        = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                swarq_pkg::REG_TOTAL_BYTES:
                begin
                    remaining_next = cfg_data[TOT_W-1:0];
                end
                swarq_pkg::REG_TIMEOUT:
                begin
                    timeout_next = cfg_data[TMO_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.start)
        begin
            ack_next = ack_seq;
            idx_next = '0;
            if (mode == swarq_pkg::MODE_TICK)
            begin
                now_next = now_reg + SEQ_W'(1);
            end
        end

        if (cmd.scan_step)
        begin
            idx_next = idx_reg + CNT_W'(1);
            if (timed_out)
            begin
                wr_en     = 1'b1;
                produce   = 1'b1;
                new_kind  = swarq_pkg::KIND_RESEND;
                new_seq   = base_reg + SEQ_W'(idx_reg);
                new_bytes = rd_size;
            end
        end

        if (cmd.fill_step)
        begin
            wr_en            = 1'b1;
            wr_size_en       = 1'b1;
            produce          = 1'b1;
            new_kind         = swarq_pkg::KIND_NEW;
            new_seq          = next_seq_reg;
            new_bytes        = chunk;
            outstanding_next = outstanding_reg + CNT_W'(1);
            remaining_next   = remaining_reg - TOT_W'(chunk);
            next_seq_next    = next_seq_reg + SEQ_W'(1);
            if (rem_short)
            begin
                all_loaded_next = 1'b1;
            end
        end

        if (cmd.finish_step)
        begin
            if (all_loaded_reg && (outstanding_reg == '0) && !done_reg)
            begin
                produce   = 1'b1;
                new_kind  = swarq_pkg::KIND_FINISH;
                new_seq   = next_seq_reg;
                done_next = 1'b1;
            end
        end

        if (cmd.ack_step)
        begin
            if ((outstanding_reg != '0) && !ack_dist[SEQ_W-1])
            begin
                if (ack_dist >= SEQ_W'(outstanding_reg))
                begin
                    produce  = 1'b1;
                    new_kind = swarq_pkg::KIND_REJECT;
                    new_seq  = ack_reg;
                end
                else
                begin
                    base_next        = base_reg + SEQ_W'(drop);
                    outstanding_next = outstanding_reg - drop;
                    head_next        = head_wrap[IDX_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        push            = (produce && pend_valid_reg) || cmd.flush_step;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_seq_next   = pend_seq_reg;
        pend_bytes_next = pend_bytes_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_seq_next    = out_seq_reg;
        out_bytes_next  = out_bytes_reg;
        out_last_next   = out_last_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (push)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = pend_kind_reg;
            out_seq_next   = pend_seq_reg;
            out_bytes_next = pend_bytes_reg;
            out_last_next  = cmd.flush_step;
        end
        if (cmd.flush_step)
        begin
            pend_valid_next = 1'b0;
        end
        if (produce)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = new_kind;
            pend_seq_next   = new_seq;
            pend_bytes_next = new_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= swarq_pkg::TIMEOUT_RESET;
            remaining_reg   <= '0;
            next_seq_reg    <= '0;
            base_reg        <= '0;
            outstanding_reg <= '0;
            head_reg        <= '0;
            idx_reg         <= '0;
            all_loaded_reg  <= 1'b0;
            done_reg        <= 1'b0;
            now_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            timeout_reg     <= timeout_next;
            remaining_reg   <= remaining_next;
            next_seq_reg    <= next_seq_next;
            base_reg        <= base_next;
            outstanding_reg <= outstanding_next;
            head_reg        <= head_next;
            idx_reg         <= idx_next;
            all_loaded_reg  <= all_loaded_next;
            done_reg        <= done_next;
            now_reg         <= now_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg        <= ack_next;
        pend_kind_reg  <= pend_kind_next;
        pend_seq_reg   <= pend_seq_next;
        pend_bytes_reg <= pend_bytes_next;
        out_kind_reg   <= out_kind_next;
        out_seq_reg    <= out_seq_next;
        out_bytes_reg  <= out_bytes_next;
        out_last_reg   <= out_last_next;
        if (wr_en)
        begin
            stamp_reg[slot] <= wr_stamp;
            if (wr_size_en)
            begin
                size_reg[slot] <= wr_size;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign seq_num       = out_seq_reg;
    assign payload_bytes = out_bytes_reg;
    assign last          = out_last_reg;

endmodule

// ----- sv/sliding_window_arq_sender_top.sv -----
// Sender side of a sliding-window ARQ with cumulative acknowledgements.
// Requests enter on the input channel (in_valid, in_stall, mode, ack_seq):
// a mode of zero is a time tick, a mode of one an acknowledgement.
// Each request yields zero or more results on the output channel (out_valid,
// out_stall, kind, seq_num, payload_bytes, last); last marks the final
// result of a request.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Writing total_bytes reloads the remaining byte count.
// A tick checks one outstanding entry per cycle, then loads one new chunk
// per cycle, each only while the output path can take a result, and then
// makes the finish check and sends the last result, if there is one. An
// acknowledgement is checked and applied or rejected, then any result sent.
// Each result waits in a pending register until the next result of the same
// request is produced or the request ends, and is offered in the next cycle.
// When the receiver holds out_stall, results wait in the output register and
// one pending register, and the scan and fill pause until one of them frees.
// Reset clears all counters and the remaining byte count, empties the window
// and sets timeout_ticks to 80.
module sliding_window_arq_sender_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic [swarq_pkg::SEQ_W-1:0]          ack_seq,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [swarq_pkg::KIND_W-1:0]         kind,
    output logic [swarq_pkg::SEQ_W-1:0]          seq_num,
    output logic [swarq_pkg::BYTES_W-1:0]        payload_bytes,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic [swarq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swarq_pkg::CFG_W-1:0]          cfg_data
);

    swarq_pkg::cmd_t    cmd;
    swarq_pkg::status_t st;

    swarq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    swarq_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .ack_seq       (ack_seq),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .st            (st),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .seq_num       (seq_num),
        .payload_bytes (payload_bytes),
        .last          (last)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int WIN_DEPTH   = swarq_pkg::WIN_DEPTH;
    localparam int MAX_PAYLOAD = swarq_pkg::MAX_PAYLOAD;
    localparam int SEQ_W       = swarq_pkg::SEQ_W;
    localparam int BYTES_W     = swarq_pkg::BYTES_W;
    localparam int KIND_W      = swarq_pkg::KIND_W;
    localparam int CFG_W       = swarq_pkg::CFG_W;
    localparam int CFG_IDX_W   = swarq_pkg::CFG_IDX_W;
    localparam int TOTAL_W     = swarq_pkg::TOTAL_W;
    localparam int TIMEOUT_W   = swarq_pkg::TIMEOUT_W;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = WIN_DEPTH + 8;
    localparam int RANDOM_TARGET = 130;
    localparam int MAX_GAP       = 18;

    typedef swarq_pkg::kind_t kind_t;

    typedef struct {
        kind_t              kind;
        logic [SEQ_W-1:0]   seq;
        logic [BYTES_W-1:0] bytes;
        logic               last;
    } frame_t;

    typedef enum int {OP_SET_TOTAL, OP_SET_TIMEOUT, OP_TICK, OP_ACK} row_op_t;

    typedef struct {
        row_op_t          op;
        logic [CFG_W-1:0] value;
        int               typed_n;
        kind_t            kind;
        logic [SEQ_W-1:0] seq;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic [SEQ_W-1:0]     ack_seq;
    logic                 out_valid;
    logic                 out_stall;
    logic [KIND_W-1:0]    kind;
    logic [SEQ_W-1:0]     seq_num;
    logic [BYTES_W-1:0]   payload_bytes;
    logic                 last;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic [TOTAL_W-1:0]   total_reg   = '0;
    logic [TOTAL_W-1:0]   left_bytes  = '0;
    logic [TIMEOUT_W-1:0] timeout_reg = swarq_pkg::TIMEOUT_RESET;
    logic [SEQ_W-1:0]     next_seq_p  = '0;
    logic [SEQ_W-1:0]     base_p      = '0;
    logic [SEQ_W-1:0]     now_p       = '0;
    int                   win_count   = 0;
    logic [SEQ_W-1:0]     stamp_p [WIN_DEPTH];
    logic [BYTES_W-1:0]   size_p [WIN_DEPTH];
    bit                   loaded      = 1'b0;
    bit                   finished    = 1'b0;

    frame_t expected[$];
    frame_t step_frames[$];
    row_t   script[$];

    bit calm_in  = 1'b0;
    bit calm_out = 1'b0;
    int errors      = 0;
    int cycle_count = 0;
    int n_ticks     = 0;
    int n_acks      = 0;
    int n_moved     = 0;
    int n_checked   = 0;
    int n_resends   = 0;
    int n_rejects   = 0;

    sliding_window_arq_sender_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .ack_seq       (ack_seq),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .seq_num       (seq_num),
        .payload_bytes (payload_bytes),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        if (errors < 50)
        begin
            $display("MISMATCH at cycle %0d: %0s", cycle_count, msg);
        end
        errors++;
    endtask

    function automatic void add_frame(input kind_t k, input logic [SEQ_W-1:0] s,
                                      input logic [BYTES_W-1:0] b);
        frame_t f;
        f.kind  = k;
        f.seq   = s;
        f.bytes = b;
        f.last  = 1'b0;
        step_frames.insert(step_frames.size(), f);
    endfunction

    function automatic void await_frame(input frame_t f);
        expected.insert(expected.size(), f);
    endfunction

    function automatic void await_step_frames();
        foreach (step_frames[k])
        begin
            await_frame(step_frames[k]);
        end
    endfunction

    // Advances the sender state by one request and leaves its results in step_frames.
    // Returns zero when the request is an acknowledgement that the sender ignores.
    function automatic bit predict_request(input logic m, input logic [SEQ_W-1:0] a);
        int                 span;
        int                 drop;
        int                 k;
        logic [SEQ_W-1:0]   age;
        logic [SEQ_W-1:0]   ack_dist;
        logic [BYTES_W-1:0] sz;
        bit                 moved;
        step_frames.delete();
        moved = 1'b1;
        if (m == swarq_pkg::MODE_TICK)
        begin
            span = win_count;
            now_p = now_p + 1;
            for (k = 0; k < span; k++)
            begin
                age = now_p - stamp_p[k];
                if (age > SEQ_W'(timeout_reg))
                begin
                    add_frame(swarq_pkg::KIND_RESEND, base_p + SEQ_W'(k), size_p[k]);
                    stamp_p[k] = now_p;
                end
            end
            while (!loaded && win_count < WIN_DEPTH)
            begin
                sz = (left_bytes < TOTAL_W'(MAX_PAYLOAD)) ? BYTES_W'(left_bytes)
                                                          : BYTES_W'(MAX_PAYLOAD);
                size_p[win_count]  = sz;
                stamp_p[win_count] = now_p;
                add_frame(swarq_pkg::KIND_NEW, base_p + SEQ_W'(win_count), sz);
                win_count++;
                left_bytes = left_bytes - TOTAL_W'(sz);
                next_seq_p = base_p + SEQ_W'(win_count);
                if (sz < BYTES_W'(MAX_PAYLOAD))
                begin
                    loaded = 1'b1;
                end
            end
            if (loaded && win_count == 0 && !finished)
            begin
                add_frame(swarq_pkg::KIND_FINISH, next_seq_p, '0);
                finished = 1'b1;
            end
        end
        else
        begin
            ack_dist = a - base_p;
            if (win_count == 0 || ack_dist[SEQ_W-1])
            begin
                moved = 1'b0;
            end
            else if (ack_dist >= SEQ_W'(win_count))
            begin
                add_frame(swarq_pkg::KIND_REJECT, a, '0);
            end
            else
            begin
                drop = int'(ack_dist) + 1;
                for (k = 0; k < win_count - drop; k++)
                begin
                    stamp_p[k] = stamp_p[k + drop];
                    size_p[k]  = size_p[k + drop];
                end
                base_p = base_p + SEQ_W'(drop);
                win_count = win_count - drop;
            end
        end
        if (step_frames.size() > 0)
        begin
            step_frames[step_frames.size() - 1].last = 1'b1;
        end
        return moved;
    endfunction

    task automatic send_request(input logic m, input logic [SEQ_W-1:0] a);
        int gap;
        gap = calm_in ? 0 : $urandom_range(MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        ack_seq  <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (predict_request(m, a))
        begin
            n_moved++;
        end
        if (m == swarq_pkg::MODE_TICK)
        begin
            n_ticks++;
        end
        else
        begin
            n_acks++;
        end
    endtask

    // Registers change only once the sender has drained every result and gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == swarq_pkg::REG_TOTAL_BYTES)
        begin
            total_reg  = value[TOTAL_W-1:0];
            left_bytes = total_reg;
        end
        else
        begin
            timeout_reg = value[TIMEOUT_W-1:0];
        end
    endtask

    task automatic random_request(input bit closing);
        int               pick;
        logic [SEQ_W-1:0] a;
        pick = $urandom_range(99);
        if (pick < (closing ? 35 : 45))
        begin
            send_request(swarq_pkg::MODE_TICK, $urandom);
        end
        else
        begin
            if (pick < 85 && win_count > 0)
            begin
                if ($urandom_range(3) == 0)
                begin
                    a = base_p + SEQ_W'(win_count - 1);
                end
                else
                begin
                    a = base_p + $urandom_range(win_count - 1);
                end
            end
            else if (pick < 91)
            begin
                a = ($urandom_range(1) == 0) ? base_p - 1 - $urandom_range(1000)
                                             : base_p + 32'h8000_0000 + $urandom_range(1000);
            end
            else if (pick < 96)
            begin
                a = base_p + SEQ_W'(win_count) + $urandom_range(40);
            end
            else
            begin
                a = $urandom;
            end
            send_request(swarq_pkg::MODE_ACK, a);
        end
        await_step_frames();
    endtask

    function automatic row_t mk(input row_op_t op, input logic [CFG_W-1:0] value,
                                input int typed_n, input kind_t k, input logic [SEQ_W-1:0] s);
        row_t r;
        r.op      = op;
        r.value   = value;
        r.typed_n = typed_n;
        r.kind    = k;
        r.seq     = s;
        return r;
    endfunction

    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = calm_out ? 0 : $urandom_range(MAX_GAP);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected.size() == 0)
            begin
                note_mismatch($sformatf("result with nothing awaited: kind %0d seq %0d bytes %0d",
                                        kind, seq_num, payload_bytes));
            end
            else
            begin
                want = expected[0];
                expected.delete(0);
                n_checked++;
                if (want.kind == swarq_pkg::KIND_RESEND)
                begin
                    n_resends++;
                end
                if (want.kind == swarq_pkg::KIND_REJECT)
                begin
                    n_rejects++;
                end
                if (kind_t'(kind) != want.kind)
                begin
                    note_mismatch($sformatf("kind %0d, expected %0d (seq %0d)",
                                            kind, want.kind, want.seq));
                end
                if (seq_num != want.seq)
                begin
                    note_mismatch($sformatf("seq_num %0d, expected %0d", seq_num, want.seq));
                end
                if (payload_bytes != want.bytes)
                begin
                    note_mismatch($sformatf("payload_bytes %0d, expected %0d (seq %0d)",
                                            payload_bytes, want.bytes, want.seq));
                end
                if (last != want.last)
                begin
                    note_mismatch($sformatf("last %0d, expected %0d (seq %0d)",
                                            last, want.last, want.seq));
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results still awaited.",
                 cycle_count, expected.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int               t;
        int               tail;
        int               guard;
        logic [CFG_W-1:0] close_total;
        frame_t           fixed_f;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = swarq_pkg::MODE_TICK;
        ack_seq   = '0;
        cfg_we    = 1'b0;
        cfg_index = swarq_pkg::REG_TOTAL_BYTES;
        cfg_data  = '0;

        script.insert(script.size(), mk(OP_SET_TOTAL, 40'hFF_FFFF_FFFF, -1,
                                        swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_SET_TIMEOUT, 1, -1, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_TICK, 0, -1, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_TICK, 0, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_TICK, 0, -1, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_ACK, 3, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_ACK, 2, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_ACK, 20, 1, swarq_pkg::KIND_REJECT, 20));
        script.insert(script.size(), mk(OP_ACK, 32'hFFFF_FFFF, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_ACK, 32'h8000_0003, 1, swarq_pkg::KIND_REJECT,
                                        32'h8000_0003));
        script.insert(script.size(), mk(OP_ACK, 32'h8000_0004, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_TICK, 0, -1, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_SET_TIMEOUT, 65535, -1, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_TICK, 32'hFFFF_FFFF, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_ACK, 19, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_ACK, 20, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_ACK, 0, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_SET_TIMEOUT, 0, -1, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_TICK, 0, -1, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_TICK, 0, -1, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_ACK, 35, 0, swarq_pkg::KIND_NEW, '0));
        script.insert(script.size(), mk(OP_SET_TIMEOUT, 80, -1, swarq_pkg::KIND_NEW, '0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            case (script[r].op)
                OP_SET_TOTAL:   write_reg(swarq_pkg::REG_TOTAL_BYTES, script[r].value);
                OP_SET_TIMEOUT: write_reg(swarq_pkg::REG_TIMEOUT, script[r].value);
                default:
                begin
                    send_request(script[r].op == OP_ACK ? swarq_pkg::MODE_ACK
                                                        : swarq_pkg::MODE_TICK,
                                 script[r].value[SEQ_W-1:0]);
                    if (script[r].typed_n < 0)
                    begin
                        await_step_frames();
                    end
                    else if (script[r].typed_n == 1)
                    begin
                        fixed_f.kind  = script[r].kind;
                        fixed_f.seq   = script[r].seq;
                        fixed_f.bytes = '0;
                        fixed_f.last  = 1'b1;
                        await_frame(fixed_f);
                    end
                end
            endcase
        end

        while (n_ticks + n_acks < RANDOM_TARGET)
        begin
            case ($urandom_range(5))
                0:       t = 1;
                1:       t = 2;
                2:       t = $urandom_range(3, 12);
                3:       t = $urandom_range(13, 60);
                4:       t = 65535;
                default: t = 0;
            endcase
            write_reg(swarq_pkg::REG_TIMEOUT, CFG_W'(t));
            if ($urandom_range(2) == 0)
            begin
                write_reg(swarq_pkg::REG_TOTAL_BYTES,
                          {8'($urandom_range(1, 255)), 32'($urandom)});
            end
            calm_in  = ($urandom_range(3) == 0);
            calm_out = ($urandom_range(3) == 0);
            repeat ($urandom_range(8, 16)) random_request(1'b0);
        end

        case ($urandom_range(2))
            0:       close_total = '0;
            1:       close_total = CFG_W'(MAX_PAYLOAD * $urandom_range(1, 24));
            default: close_total = CFG_W'($urandom_range(1, 30000));
        endcase
        calm_in  = 1'b0;
        calm_out = 1'b0;
        write_reg(swarq_pkg::REG_TIMEOUT, CFG_W'($urandom_range(2, 6)));
        write_reg(swarq_pkg::REG_TOTAL_BYTES, close_total);
        tail  = 0;
        guard = 0;
        while (tail < 4 && guard < 20)
        begin
            random_request(1'b1);
            guard++;
            if (finished)
            begin
                tail++;
            end
        end

        in_valid <= 1'b0;
        while (expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d ticks, %0d acknowledgements, %0d of them effective),",
                 n_ticks + n_acks, n_ticks, n_acks, n_moved);
        $display("checked %0d results with %0d resends and %0d rejected acknowledgements;",
                 n_checked, n_resends, n_rejects);
        $display("closing total %0d bytes, %0s.", close_total,
                 finished ? "transfer finished" : "transfer still open");
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
